// ===== sv/smeu_pkg.sv =====
// shared types, sizes and codes of the stack machine execute unit
package smeu_pkg;

    localparam int MEM_WORDS   = 16384;
    localparam int STACK_WORDS = 256;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam int STK_AW      = $clog2(STACK_WORDS);
    localparam int CNT_W       = $clog2(STACK_WORDS + 1);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_PCNEG = 3'd1;
    localparam logic [2:0] ERR_OP    = 3'd2;
    localparam logic [2:0] ERR_EMPTY = 3'd3;
    localparam logic [2:0] ERR_INDEX = 3'd4;
    localparam logic [2:0] ERR_DIV0  = 3'd5;
    localparam logic [2:0] ERR_ADDR  = 3'd6;
    localparam logic [2:0] ERR_OVF   = 3'd7;

    localparam logic [7:0] OP_D0    = 8'h30;
    localparam logic [7:0] OP_D9    = 8'h39;
    localparam logic [7:0] OP_ADD   = 8'h2B;
    localparam logic [7:0] OP_SUB   = 8'h2D;
    localparam logic [7:0] OP_MUL   = 8'h2A;
    localparam logic [7:0] OP_DIV   = 8'h2F;
    localparam logic [7:0] OP_CMP   = 8'h3A;
    localparam logic [7:0] OP_JMP   = 8'h67;
    localparam logic [7:0] OP_JZ    = 8'h3F;
    localparam logic [7:0] OP_LD    = 8'h3C;
    localparam logic [7:0] OP_ST    = 8'h3E;
    localparam logic [7:0] OP_PICK  = 8'h5E;
    localparam logic [7:0] OP_ROLL  = 8'h76;
    localparam logic [7:0] OP_DROP  = 8'h64;
    localparam logic [7:0] OP_PRN   = 8'h70;
    localparam logic [7:0] OP_PRC   = 8'h50;
    localparam logic [7:0] OP_HALT  = 8'h21;
    localparam logic [7:0] OP_SPACE = 8'h20;
    localparam logic [7:0] OP_NOPC  = 8'h63;
    localparam logic [7:0] OP_NOPD  = 8'h24;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         opcode_char;
        logic [13:0]        load_address;
        logic signed [31:0] load_value;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic [1:0]         run_status;
        logic [2:0]         error_code;
        logic               print_valid;
        logic               print_as_char;
        logic signed [31:0] print_value;
    } t_out;

endpackage

// ===== sv/smeu_ram.sv =====
// generic single write port ram with registered read
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/stack_machine_execute_unit_core.sv =====
// stack machine execute unit: sequencer, stack and data memories, bit-serial divider
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one command per
// transaction: load a data memory word, execute one opcode, or start a run.
// Output channel (o_out_valid / i_out_ready, payload o_out) returns one result
// per transaction with the pc to fetch next, run status, error and print data.
// program_length is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while idle, and the block itself does not enforce this. '/' computes one
// quotient bit a cycle, 'v' moves the stack entries one by one through the single
// stack ram write port, and start runs a clearing pass over the data memory, one
// word a cycle. Only one transaction is in work at a time. After reset a clearing
// pass over the data memory runs before o_in_ready rises. A result waits in an
// output register; the next transaction is taken while it waits and its own
// result holds until the receiver takes the earlier one.
module stack_machine_execute_unit_core
    import smeu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_GOT_A    = 4'd3;
    localparam logic [3:0] S_GOT_B    = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_MEMRD    = 4'd6;
    localparam logic [3:0] S_PICK     = 4'd7;
    localparam logic [3:0] S_ROLL     = 4'd8;
    localparam logic [3:0] S_ROLL_END = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]        r_state;
    logic [MEM_AW-1:0] r_clr;
    logic              r_clr_report;
    t_in               r_in;
    logic [15:0]       r_plen;
    logic [CNT_W-1:0]  r_cnt;
    logic [31:0]       r_pc;
    logic [1:0]        r_status;
    logic [2:0]        r_err;
    logic [31:0]       r_a;
    logic [31:0]       r_r;
    logic [31:0]       r_jump;
    logic [STK_AW-1:0] r_idx;
    logic [STK_AW-1:0] r_i;
    logic [31:0]       r_quo;
    logic [31:0]       r_rem;
    logic [31:0]       r_dvs;
    logic [4:0]        r_step;
    logic              r_neg;
    logic              r_pv;
    logic              r_pch;
    logic [31:0]       r_pval;
    logic              r_ov;
    t_out              r_out;

    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr;
    logic [31:0]       stk_wdata;
    logic [STK_AW-1:0] stk_raddr;
    logic [31:0]       stk_rdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;
    logic [31:0]       mem_rdata;

    logic [7:0]       op;
    logic             is_digit, is_bin, is_one, is_two, is_nop;
    logic [CNT_W-1:0] cnt_m1, cnt_m2;
    logic             run_ok, stk_full;
    logic [31:0]      load_addr32;
    logic             load_ok;
    logic [31:0]      alu_r;
    logic [STK_AW-1:0] idx_c;
    logic             pick_bad;
    logic             a_bad_addr;
    logic [32:0]      div_t;
    logic             div_ge;
    logic [31:0]      div_rem_n;
    logic [31:0]      div_quo_n;
    logic [31:0]      div_res;
    logic             roll_more_pick;
    logic             roll_more;
    logic [31:0]      fin_pc;
    logic             accept;
    logic             out_free;
    logic [15:0]      sat_pc;
    logic [31:0]      chr_val;

    assign op       = r_in.opcode_char;
    assign is_digit = (op >= OP_D0) && (op <= OP_D9);
    assign is_bin   = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
                      (op == OP_DIV) || (op == OP_CMP);
    assign is_two   = is_bin || (op == OP_JZ) || (op == OP_ST);
    assign is_one   = (op == OP_JMP) || (op == OP_DROP) || (op == OP_PRN) ||
                      (op == OP_PRC) || (op == OP_LD) || (op == OP_PICK) ||
                      (op == OP_ROLL);
    assign is_nop   = (op == OP_SPACE) || (op == OP_NOPC) || (op == OP_NOPD);

    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);
    assign stk_full = (r_cnt == CNT_W'(STACK_WORDS));
    assign run_ok   = (r_status == ST_RUN) && !r_pc[31] && (r_pc < {16'd0, r_plen});

    assign load_addr32 = {18'd0, r_in.load_address};
    assign load_ok     = load_addr32 < 32'(MEM_WORDS);

    assign a_bad_addr = stk_rdata >= 32'(MEM_WORDS);
    assign pick_bad   = stk_rdata >= 32'(cnt_m1);
    assign idx_c      = cnt_m2[STK_AW-1:0] - stk_rdata[STK_AW-1:0];

    always_comb begin
        unique case (op)
            OP_ADD:  alu_r = stk_rdata + r_a;
            OP_SUB:  alu_r = stk_rdata - r_a;
            OP_MUL:  alu_r = stk_rdata * r_a;
            default: alu_r = ($signed(stk_rdata) < $signed(r_a)) ? 32'hFFFF_FFFF :
                             ((stk_rdata == r_a) ? 32'd0 : 32'd1);
        endcase
    end

    assign div_t     = {r_rem, r_quo[31]};
    assign div_ge    = div_t >= {1'b0, r_dvs};
    assign div_rem_n = div_ge ? 32'(div_t - {1'b0, r_dvs}) : div_t[31:0];
    assign div_quo_n = {r_quo[30:0], div_ge};
    assign div_res   = r_neg ? (32'd0 - div_quo_n) : div_quo_n;

    assign roll_more_pick = (CNT_W'(r_idx) + CNT_W'(1)) < cnt_m1;
    assign roll_more      = (CNT_W'(r_i) + CNT_W'(2)) < cnt_m1;

    assign fin_pc  = r_pc + 32'd1 + r_jump;
    assign chr_val = stk_rdata[31] ? (32'd0 - ((32'd0 - stk_rdata) & 32'h0000_00FF))
                                   : {24'd0, stk_rdata[7:0]};

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign sat_pc   = r_pc[31] ? 16'd0 : ((|r_pc[30:16]) ? 16'hFFFF : r_pc[15:0]);

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = cnt_m1[STK_AW-1:0];
        stk_wdata = alu_r;
        stk_raddr = cnt_m1[STK_AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = load_addr32[MEM_AW-1:0];
        mem_wdata = r_in.load_value;
        mem_raddr = stk_rdata[MEM_AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 32'd0;
            end
            S_DISP: begin
                if (r_in.cmd == CMD_LOAD && load_ok) begin
                    mem_we = 1'b1;
                end
                if (r_in.cmd == CMD_EXEC && run_ok && is_digit && !stk_full) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_cnt[STK_AW-1:0];
                    stk_wdata = {28'd0, op[3:0]};
                end
            end
            S_GOT_A: begin
                if (is_two) begin
                    stk_raddr = cnt_m2[STK_AW-1:0];
                end else begin
                    stk_raddr = idx_c;
                end
            end
            S_GOT_B: begin
                stk_waddr = cnt_m2[STK_AW-1:0];
                if (is_bin && op != OP_DIV) begin
                    stk_we = 1'b1;
                end
                mem_waddr = r_a[MEM_AW-1:0];
                mem_wdata = stk_rdata;
                if (op == OP_ST && r_a < 32'(MEM_WORDS)) begin
                    mem_we = 1'b1;
                end
            end
            S_DIV: begin
                stk_waddr = cnt_m2[STK_AW-1:0];
                stk_wdata = div_res;
                stk_we    = (r_step == 5'd31);
            end
            S_MEMRD: begin
                stk_we    = 1'b1;
                stk_wdata = mem_rdata;
            end
            S_PICK: begin
                stk_wdata = stk_rdata;
                stk_raddr = r_idx + STK_AW'(1);
                if (op == OP_PICK) begin
                    stk_we = 1'b1;
                end else if (!roll_more_pick) begin
                    stk_we    = 1'b1;
                    stk_waddr = cnt_m2[STK_AW-1:0];
                end
            end
            S_ROLL: begin
                stk_we    = 1'b1;
                stk_waddr = r_i;
                stk_wdata = stk_rdata;
                stk_raddr = r_i + STK_AW'(2);
            end
            S_ROLL_END: begin
                stk_we    = 1'b1;
                stk_waddr = cnt_m2[STK_AW-1:0];
                stk_wdata = r_r;
            end
            default: begin
            end
        endcase
    end

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    smeu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_clr_report <= 1'b0;
            r_plen       <= 16'd0;
            r_cnt        <= '0;
            r_pc         <= 32'd0;
            r_status     <= ST_RUN;
            r_err        <= ERR_NONE;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in    <= i_in;
                        r_pv    <= 1'b0;
                        r_pch   <= 1'b0;
                        r_pval  <= 32'd0;
                        r_jump  <= 32'd0;
                        r_state <= S_DISP;
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + MEM_AW'(1);
                    if (r_clr == MEM_AW'(MEM_WORDS - 1)) begin
                        r_state <= r_clr_report ? S_DONE : S_IDLE;
                    end
                end
                S_DISP: begin
                    r_state <= S_DONE;
                    if (r_in.cmd == CMD_START) begin
                        r_cnt        <= '0;
                        r_pc         <= 32'd0;
                        r_err        <= ERR_NONE;
                        r_status     <= (r_plen == 16'd0) ? ST_END : ST_RUN;
                        r_clr        <= '0;
                        r_clr_report <= 1'b1;
                        r_state      <= S_CLEAR;
                    end else if (r_in.cmd == CMD_EXEC && r_status == ST_RUN) begin
                        if (r_pc[31]) begin
                            r_status <= ST_ERR;
                            r_err    <= ERR_PCNEG;
                        end else if (!run_ok) begin
                            r_status <= ST_END;
                        end else if (is_digit) begin
                            if (stk_full) begin
                                r_status <= ST_ERR;
                                r_err    <= ERR_OVF;
                            end else begin
                                r_cnt   <= r_cnt + CNT_W'(1);
                                r_state <= S_FINISH;
                            end
                        end else if (op == OP_HALT) begin
                            r_status <= ST_HALT;
                        end else if (is_nop) begin
                            r_state <= S_FINISH;
                        end else if (is_two) begin
                            if (r_cnt < CNT_W'(2)) begin
                                r_status <= ST_ERR;
                                r_err    <= ERR_EMPTY;
                            end else begin
                                r_state <= S_GOT_A;
                            end
                        end else if (is_one) begin
                            if (r_cnt == '0) begin
                                r_status <= ST_ERR;
                                r_err    <= ERR_EMPTY;
                            end else begin
                                r_state <= S_GOT_A;
                            end
                        end else begin
                            r_status <= ST_ERR;
                            r_err    <= ERR_OP;
                        end
                    end
                end
                S_GOT_A: begin
                    r_a     <= stk_rdata;
                    r_idx   <= idx_c;
                    r_state <= S_FINISH;
                    if (is_two) begin
                        r_state <= S_GOT_B;
                    end else if (op == OP_LD) begin
                        if (a_bad_addr) begin
                            r_status <= ST_ERR;
                            r_err    <= ERR_ADDR;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_MEMRD;
                        end
                    end else if (op == OP_PICK || op == OP_ROLL) begin
                        if (pick_bad) begin
                            r_status <= ST_ERR;
                            r_err    <= ERR_INDEX;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end else begin
                        r_cnt <= cnt_m1;
                        if (op == OP_JMP) begin
                            r_jump <= stk_rdata;
                        end else if (op == OP_PRN) begin
                            r_pv   <= 1'b1;
                            r_pval <= stk_rdata;
                        end else if (op == OP_PRC) begin
                            r_pv   <= 1'b1;
                            r_pch  <= 1'b1;
                            r_pval <= chr_val;
                        end
                    end
                end
                S_GOT_B: begin
                    r_state <= S_FINISH;
                    if (op == OP_DIV) begin
                        if (r_a == 32'd0) begin
                            r_status <= ST_ERR;
                            r_err    <= ERR_DIV0;
                            r_state  <= S_DONE;
                        end else begin
                            r_quo   <= stk_rdata[31] ? (32'd0 - stk_rdata) : stk_rdata;
                            r_dvs   <= r_a[31] ? (32'd0 - r_a) : r_a;
                            r_rem   <= 32'd0;
                            r_step  <= 5'd0;
                            r_neg   <= stk_rdata[31] ^ r_a[31];
                            r_state <= S_DIV;
                        end
                    end else if (is_bin) begin
                        r_cnt <= cnt_m1;
                    end else if (op == OP_ST && r_a >= 32'(MEM_WORDS)) begin
                        r_status <= ST_ERR;
                        r_err    <= ERR_ADDR;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt <= cnt_m2;
                        if (op == OP_JZ && stk_rdata == 32'd0) begin
                            r_jump <= r_a;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= div_rem_n;
                    r_quo  <= div_quo_n;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_cnt   <= cnt_m1;
                        r_state <= S_FINISH;
                    end
                end
                S_MEMRD: begin
                    r_state <= S_FINISH;
                end
                S_PICK: begin
                    r_r     <= stk_rdata;
                    r_i     <= r_idx;
                    r_state <= S_FINISH;
                    if (op == OP_ROLL) begin
                        if (roll_more_pick) begin
                            r_state <= S_ROLL;
                        end else begin
                            r_cnt <= cnt_m1;
                        end
                    end
                end
                S_ROLL: begin
                    r_i <= r_i + STK_AW'(1);
                    if (!roll_more) begin
                        r_state <= S_ROLL_END;
                    end
                end
                S_ROLL_END: begin
                    r_cnt   <= cnt_m1;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_pc    <= fin_pc;
                    r_state <= S_DONE;
                    if (fin_pc[31]) begin
                        r_status <= ST_ERR;
                        r_err    <= ERR_PCNEG;
                    end else if (fin_pc >= {16'd0, r_plen}) begin
                        r_status <= ST_END;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.next_pc       <= sat_pc;
                        r_out.run_status    <= r_status;
                        r_out.error_code    <= r_err;
                        r_out.print_valid   <= r_pv;
                        r_out.print_as_char <= r_pch;
                        r_out.print_value   <= r_pval;
                        r_clr_report        <= 1'b0;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_WORDS))
        else $error("stack count above depth");

    a_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_ERR) == (r_err != ERR_NONE))
        else $error("error code and status disagree");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.print_valid) |->
        (!o_out.print_as_char && o_out.print_value == 32'sd0))
        else $error("print fields set without print");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after a transaction");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("pending result changed");

endmodule
